// ===== rtl/core/rrpst_pkg.sv =====
package rrpst_pkg;

    // request kinds carried in the input tuser
    localparam logic [1:0] KIND_ADD     = 2'd0;
    localparam logic [1:0] KIND_REMOVE  = 2'd1;
    localparam logic [1:0] KIND_REPLACE = 2'd2;
    localparam logic [1:0] KIND_TICK    = 2'd3;

    // result causes carried in the output tuser
    localparam logic [1:0] CAUSE_FIRST    = 2'd0;
    localparam logic [1:0] CAUSE_EMPTIED  = 2'd1;
    localparam logic [1:0] CAUSE_ROTATION = 2'd2;
    localparam logic [1:0] CAUSE_OVERFLOW = 2'd3;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic add_step;
        logic rm_step;
        logic tick_step;
        logic out_load;
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic [1:0] kind;
        logic       page_zero;
        logic       copies_zero;
        logic       table_empty;
        logic       scan_last;
        logic       rscan_done;
        logic       tick_hit;
        logic       res_valid;
    } t_dp_sts;

endpackage

// ===== rtl/core/rrpst_ctrl.sv =====
module rrpst_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_out_busy,
    input  rrpst_pkg::t_dp_sts i_sts,
    output rrpst_pkg::t_dp_cmd o_cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DISP  = 3'd1;
    localparam logic [2:0] ST_ADD   = 3'd2;
    localparam logic [2:0] ST_RSCAN = 3'd3;
    localparam logic [2:0] ST_TSCAN = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DISP;
                end
            end
            ST_DISP: begin
                case (i_sts.kind)
                    rrpst_pkg::KIND_ADD: begin
                        n_state = (i_sts.page_zero || i_sts.copies_zero) ? ST_IDLE : ST_ADD;
                    end
                    rrpst_pkg::KIND_REMOVE, rrpst_pkg::KIND_REPLACE: begin
                        n_state = i_sts.page_zero ? ST_IDLE : ST_RSCAN;
                    end
                    default: begin
                        n_state = i_sts.table_empty ? ST_IDLE : ST_TSCAN;
                    end
                endcase
            end
            ST_ADD: begin
                o_cmd.add_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_RSCAN: begin
                if (i_sts.rscan_done) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.rm_step = 1'b1;
                end
            end
            ST_TSCAN: begin
                o_cmd.tick_step = 1'b1;
                if (i_sts.tick_hit) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!i_sts.res_valid) begin
                    n_state = ST_IDLE;
                end else if (!i_out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/rrpst_datapath.sv =====
module rrpst_datapath #(
    parameter int QUEUE_SLOTS = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rrpst_pkg::t_dp_cmd i_cmd,
    input  logic [1:0]         i_kind,
    input  logic [7:0]         i_page_id,
    input  logic [63:0]        i_page_payload,
    input  logic [4:0]         i_copy_count,
    output rrpst_pkg::t_dp_sts o_sts,
    output logic [63:0]        o_res_payload,
    output logic [1:0]         o_res_cause,
    output logic               o_res_overflow
);

    localparam int IW = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
    localparam int CW = $clog2(QUEUE_SLOTS + 1);
    localparam logic [IW-1:0] LastIdx = IW'(QUEUE_SLOTS - 1);

    // slot stores
    logic [7:0]  r_tag_mem  [QUEUE_SLOTS];
    logic [63:0] r_data_mem [QUEUE_SLOTS];
    logic [QUEUE_SLOTS-1:0] r_valid;

    // request capture
    logic [1:0]  r_kind;
    logic [7:0]  r_page;
    logic [63:0] r_payload;
    logic [4:0]  r_remain;
    logic        r_was_empty;
    logic        r_placed;
    logic        r_removed;

    // scan state
    logic [IW-1:0] r_idx;
    logic [IW-1:0] r_idx_q;
    logic          r_pend;
    logic          r_rd_done;
    logic [7:0]    r_tag_q;
    logic [63:0]   r_rd_data;
    logic [IW-1:0] r_cursor;
    logic [CW-1:0] r_count;

    logic [IW-1:0] w_idx_inc;
    logic [IW-1:0] w_cursor_next;
    logic          w_add_wr;
    logic          w_match;
    logic          w_rm_clr;
    logic          w_rp_wr;
    logic          w_res_valid;

    assign w_idx_inc     = (r_idx == LastIdx) ? '0 : r_idx + IW'(1);
    assign w_cursor_next = (r_cursor == LastIdx) ? '0 : r_cursor + IW'(1);
    assign w_add_wr      = i_cmd.add_step && !r_valid[r_idx] && (r_remain != 5'd0);
    assign w_match       = r_pend && r_valid[r_idx_q] && (r_tag_q == r_page);
    assign w_rm_clr      = i_cmd.rm_step && w_match && (r_kind == rrpst_pkg::KIND_REMOVE);
    assign w_rp_wr       = i_cmd.rm_step && w_match && (r_kind == rrpst_pkg::KIND_REPLACE);

    // tag and payload memories, registered reads at the scan index
    always_ff @(posedge i_clk) begin
        if (w_add_wr) begin
            r_tag_mem[r_idx] <= r_page;
        end
        if (w_add_wr) begin
            r_data_mem[r_idx] <= r_payload;
        end else if (w_rp_wr) begin
            r_data_mem[r_idx_q] <= r_payload;
        end
        r_tag_q   <= r_tag_mem[r_idx];
        r_rd_data <= r_data_mem[r_idx];
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_page    <= i_page_id;
            r_payload <= i_page_payload;
        end
        if (i_cmd.rm_step) begin
            r_idx_q <= r_idx;
        end
    end

    // occupancy, cursor and scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_count     <= '0;
            r_cursor    <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_rd_done   <= 1'b0;
            r_kind      <= rrpst_pkg::KIND_ADD;
            r_remain    <= '0;
            r_was_empty <= 1'b0;
            r_placed    <= 1'b0;
            r_removed   <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_kind      <= i_kind;
                r_remain    <= i_copy_count;
                r_was_empty <= (r_count == '0);
                r_placed    <= 1'b0;
                r_removed   <= 1'b0;
                r_pend      <= 1'b0;
                r_rd_done   <= 1'b0;
                r_idx       <= (i_kind == rrpst_pkg::KIND_TICK) ? w_cursor_next : '0;
            end
            // add: fill lowest free slots, one slot per cycle
            if (i_cmd.add_step) begin
                r_idx <= w_idx_inc;
                if (w_add_wr) begin
                    r_valid[r_idx] <= 1'b1;
                    r_count        <= r_count + CW'(1);
                    r_remain       <= r_remain - 5'd1;
                    r_placed       <= 1'b1;
                end
            end
            // remove and replace: read ahead one slot, compare the previous one
            if (i_cmd.rm_step) begin
                if (!r_rd_done) begin
                    r_idx     <= w_idx_inc;
                    r_rd_done <= (r_idx == LastIdx);
                end
                r_pend <= !r_rd_done;
                if (w_rm_clr) begin
                    r_valid[r_idx_q] <= 1'b0;
                    r_count          <= r_count - CW'(1);
                    r_removed        <= 1'b1;
                end
            end
            // tick: walk forward to the next occupied slot
            if (i_cmd.tick_step) begin
                if (r_valid[r_idx]) begin
                    r_cursor <= r_idx;
                end else begin
                    r_idx <= w_idx_inc;
                end
            end
        end
    end

    // status to the controller
    assign o_sts.kind        = r_kind;
    assign o_sts.page_zero   = (r_page == 8'd0);
    assign o_sts.copies_zero = (r_remain == 5'd0);
    assign o_sts.table_empty = (r_count == '0);
    assign o_sts.scan_last   = (r_idx == LastIdx);
    assign o_sts.rscan_done  = r_rd_done && !r_pend;
    assign o_sts.tick_hit    = r_valid[r_idx];
    assign o_sts.res_valid   = w_res_valid;

    // result of the finished request
    always_comb begin
        o_res_payload  = 64'd0;
        o_res_cause    = rrpst_pkg::CAUSE_FIRST;
        o_res_overflow = 1'b0;
        w_res_valid    = 1'b0;
        case (r_kind)
            rrpst_pkg::KIND_ADD: begin
                o_res_overflow = (r_remain != 5'd0);
                if (r_was_empty && r_placed) begin
                    o_res_payload = r_payload;
                    o_res_cause   = rrpst_pkg::CAUSE_FIRST;
                    w_res_valid   = 1'b1;
                end else begin
                    o_res_cause = rrpst_pkg::CAUSE_OVERFLOW;
                    w_res_valid = (r_remain != 5'd0);
                end
            end
            rrpst_pkg::KIND_REMOVE: begin
                o_res_cause = rrpst_pkg::CAUSE_EMPTIED;
                w_res_valid = r_removed && (r_count == '0);
            end
            rrpst_pkg::KIND_REPLACE: begin
                w_res_valid = 1'b0;
            end
            default: begin
                o_res_payload = r_rd_data;
                o_res_cause   = rrpst_pkg::CAUSE_ROTATION;
                w_res_valid   = 1'b1;
            end
        endcase
    end

endmodule

// ===== rtl/core/round_robin_page_slot_table.sv =====
// Round-robin page slot table: QUEUE_SLOTS slots of (page tag, 64-bit payload) with a
// rotation cursor. One request is worked at a time; the slot scan in the datapath visits
// one slot per clock. Add scans every slot; remove and replace scan every slot with the
// tag memory read running one slot ahead of the compare; a rotation tick walks forward
// to the next occupied slot. Each of these ends in a done state that hands any result to
// the output register; that state is held for as long as an earlier result still waits
// there untaken. Requests that are ignored (page 0, zero copies, tick on an empty table)
// go back to idle from the dispatch state. A result waits in the output register while
// the next request is taken. The slot tags are qualified by reset-cleared occupancy bits,
// so no clearing pass is needed after reset.
module round_robin_page_slot_table #(
    parameter int QUEUE_SLOTS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,  // page_id[7:0], page_payload[71:8], copy_count[76:72]
    input  logic [1:0]  s_axis_tuser,  // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // broadcast_payload[63:0]
    output logic [2:0]  m_axis_tuser   // cause[1:0], overflow[2]
);

    rrpst_pkg::t_dp_cmd w_cmd;
    rrpst_pkg::t_dp_sts w_sts;
    logic [63:0] w_res_payload;
    logic [1:0]  w_res_cause;
    logic        w_res_overflow;
    logic        w_out_busy;

    logic        r_out_valid;
    logic [63:0] r_out_payload;
    logic [1:0]  r_out_cause;
    logic        r_out_overflow;

    assign w_out_busy = r_out_valid && !m_axis_tready;

    // controller
    rrpst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_out_busy (w_out_busy),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // slot stores and scan datapath
    rrpst_datapath #(
        .QUEUE_SLOTS (QUEUE_SLOTS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_kind         (s_axis_tuser),
        .i_page_id      (s_axis_tdata[7:0]),
        .i_page_payload (s_axis_tdata[71:8]),
        .i_copy_count   (s_axis_tdata[76:72]),
        .o_sts          (w_sts),
        .o_res_payload  (w_res_payload),
        .o_res_cause    (w_res_cause),
        .o_res_overflow (w_res_overflow)
    );

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_cmd.out_load) begin
            r_out_payload  <= w_res_payload;
            r_out_cause    <= w_res_cause;
            r_out_overflow <= w_res_overflow;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_payload;
    assign m_axis_tuser  = {r_out_overflow, r_out_cause};

    // a pending result is never overwritten
    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> !w_out_busy)
        else $error("result loaded over a pending transfer");

    // a result is loaded only when the finished request has one
    a_load_has_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_sts.res_valid)
        else $error("result loaded for a request without one");

    // the block is busy right after accepting a request
    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while another is in progress");

    // overflow-only results carry a zero payload and the overflow flag
    a_overflow_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_cause == rrpst_pkg::CAUSE_OVERFLOW))
            |-> (r_out_overflow && (r_out_payload == 64'd0)))
        else $error("overflow result malformed");

endmodule

// ===== dv/page_table_checker.sv =====
module page_table_checker #(
    parameter int SLOT_COUNT = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_tvalid,
    input  logic        i_req_tready,
    input  logic [79:0] i_req_tdata,   // page_id[7:0], page_payload[71:8], copy_count[76:72]
    input  logic [1:0]  i_req_tuser,   // kind[1:0]
    input  logic        i_bcast_tvalid,
    input  logic        i_bcast_tready,
    input  logic [63:0] i_bcast_tdata, // broadcast_payload[63:0]
    input  logic [2:0]  i_bcast_tuser, // cause[1:0], overflow[2]
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [63:0] payload;
        logic [1:0]  cause;
        logic        overflow;
    } t_broadcast;

    // shadow copy of the slot table
    logic [7:0]  tag_mem  [SLOT_COUNT];
    logic [63:0] data_mem [SLOT_COUNT];
    int          cursor;
    int          occupancy;

    t_broadcast  queued_broadcasts [$];
    int          fail_total    = 0;
    int          pending_total = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_total;

    // back to the reset state
    task automatic clear_table();
        for (int i = 0; i < SLOT_COUNT; i++) begin
            tag_mem[i]  = 8'd0;
            data_mem[i] = 64'd0;
        end
        cursor    = 0;
        occupancy = 0;
        queued_broadcasts.delete();
    endtask

    // apply one request to the shadow table and queue the broadcast it causes
    task automatic predict_broadcast(input logic [1:0] kind, input logic [7:0] page,
                                     input logic [63:0] payload, input logic [4:0] copies);
        logic was_empty;
        logic placed;
        logic ovf;
        logic found;
        logic emptied;
        int   idx;
        case (kind)
            rrpst_pkg::KIND_ADD: begin
                if (page != 8'd0 && copies != 5'd0) begin
                    was_empty = (occupancy == 0);
                    placed    = 1'b0;
                    ovf       = 1'b0;
                    // each copy takes the lowest free slot
                    for (int c = 0; c < copies; c++) begin
                        found = 1'b0;
                        for (int i = 0; i < SLOT_COUNT; i++) begin
                            if (!found && tag_mem[i] == 8'd0) begin
                                tag_mem[i]  = page;
                                data_mem[i] = payload;
                                occupancy++;
                                placed = 1'b1;
                                found  = 1'b1;
                            end
                        end
                        if (!found) ovf = 1'b1;
                    end
                    if (was_empty && placed) begin
                        queued_broadcasts.push_back({payload, rrpst_pkg::CAUSE_FIRST, ovf});
                    end else if (ovf) begin
                        queued_broadcasts.push_back({64'd0, rrpst_pkg::CAUSE_OVERFLOW, 1'b1});
                    end
                end
            end
            rrpst_pkg::KIND_REMOVE: begin
                if (page != 8'd0) begin
                    emptied = 1'b0;
                    for (int i = 0; i < SLOT_COUNT; i++) begin
                        if (tag_mem[i] == page) begin
                            tag_mem[i] = 8'd0;
                            if (occupancy > 0) occupancy--;
                            if (occupancy == 0) emptied = 1'b1;
                        end
                    end
                    if (emptied) begin
                        queued_broadcasts.push_back({64'd0, rrpst_pkg::CAUSE_EMPTIED, 1'b0});
                    end
                end
            end
            rrpst_pkg::KIND_REPLACE: begin
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (tag_mem[i] == page) data_mem[i] = payload;
                end
            end
            rrpst_pkg::KIND_TICK: begin
                if (occupancy != 0) begin
                    found = 1'b0;
                    for (int step = 1; step <= SLOT_COUNT; step++) begin
                        idx = (cursor + step) % SLOT_COUNT;
                        if (!found && tag_mem[idx] != 8'd0) begin
                            found  = 1'b1;
                            cursor = idx;
                            queued_broadcasts.push_back({data_mem[idx],
                                                         rrpst_pkg::CAUSE_ROTATION, 1'b0});
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    // watch both channels: predict on request transfers, compare on broadcast transfers
    always @(posedge i_clk) begin
        t_broadcast want;
        if (!i_rst_n) begin
            clear_table();
            pending_total <= 0;
        end else begin
            if (i_req_tvalid && i_req_tready) begin
                predict_broadcast(i_req_tuser, i_req_tdata[7:0], i_req_tdata[71:8],
                                  i_req_tdata[76:72]);
            end
            if (i_bcast_tvalid && i_bcast_tready) begin
                if (queued_broadcasts.size() == 0) begin
                    $display("%0t: broadcast expected none actual payload %h cause %0d overflow %0d",
                             $time, i_bcast_tdata, i_bcast_tuser[1:0], i_bcast_tuser[2]);
                    fail_total++;
                end else begin
                    want = queued_broadcasts.pop_front();
                    if (i_bcast_tdata != want.payload) begin
                        $display("%0t: payload expected %h actual %h",
                                 $time, want.payload, i_bcast_tdata);
                        fail_total++;
                    end
                    if (i_bcast_tuser[1:0] != want.cause) begin
                        $display("%0t: cause expected %0d actual %0d",
                                 $time, want.cause, i_bcast_tuser[1:0]);
                        fail_total++;
                    end
                    if (i_bcast_tuser[2] != want.overflow) begin
                        $display("%0t: overflow expected %0d actual %0d",
                                 $time, want.overflow, i_bcast_tuser[2]);
                        fail_total++;
                    end
                end
            end
            pending_total <= queued_broadcasts.size();
        end
    end

endmodule

// ===== dv/tb_round_robin_page_slot_table.sv =====
module tb_round_robin_page_slot_table;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOT_COUNT   = 10;
    localparam int PHASE_ITEMS  = 660;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int SETTLE_CYCLES = 64;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata  = '0;  // page_id[7:0], page_payload[71:8], copy_count[76:72]
    logic [1:0]  s_axis_tuser  = '0;  // kind[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;        // broadcast_payload[63:0]
    logic [2:0]  m_axis_tuser;        // cause[1:0], overflow[2]

    int fail_count;
    int pending;
    int tx_idle_pct  = 31;
    int rx_idle_pct  = 53;
    bit hold_request = 1'b0;
    int hold_left    = 0;

    round_robin_page_slot_table #(
        .QUEUE_SLOTS (SLOT_COUNT)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    page_table_checker #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_tvalid   (s_axis_tvalid),
        .i_req_tready   (s_axis_tready),
        .i_req_tdata    (s_axis_tdata),
        .i_req_tuser    (s_axis_tuser),
        .i_bcast_tvalid (m_axis_tvalid),
        .i_bcast_tready (m_axis_tready),
        .i_bcast_tdata  (m_axis_tdata),
        .i_bcast_tuser  (m_axis_tuser),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // overall time limit
    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // receiver side: random stalls plus a long hold-off when one is requested
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // offer one request, with random idle cycles first, and wait for its transfer
    task automatic send_request(input logic [1:0] kind, input logic [7:0] page,
                                input logic [63:0] payload, input logic [4:0] copies);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, copies, payload, page};
        s_axis_tuser  <= kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // stop offering until every predicted broadcast has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // random traffic around a small page pool so removes and replaces hit
    task automatic send_random_requests(input int count);
        int          sent;
        int          roll;
        logic [1:0]  kind;
        logic [7:0]  page;
        logic [4:0]  copies;
        logic [63:0] payload;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 8) begin
                // clear out the whole pool so the table can empty
                for (int p = 1; p <= 4; p++) begin
                    send_request(rrpst_pkg::KIND_REMOVE, p[7:0], {$urandom, $urandom},
                                 5'($urandom_range(31)));
                end
                sent += 4;
            end else begin
                roll = $urandom_range(99);
                if (roll < 35)      kind = rrpst_pkg::KIND_ADD;
                else if (roll < 60) kind = rrpst_pkg::KIND_REMOVE;
                else if (roll < 75) kind = rrpst_pkg::KIND_REPLACE;
                else                kind = rrpst_pkg::KIND_TICK;
                page    = ($urandom_range(9) < 8) ? 8'($urandom_range(4, 1))
                                                  : 8'($urandom_range(255));
                copies  = ($urandom_range(9) < 8) ? 5'($urandom_range(3, 1))
                                                  : 5'($urandom_range(31));
                payload = {$urandom, $urandom};
                send_request(kind, page, payload, copies);
                sent++;
            end
        end
    endtask

    // stimulus and verdict
    initial begin
        int waited;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: ignored requests, first add, single-slot wrap, overflow, emptying
        send_request(rrpst_pkg::KIND_TICK,    8'd0,   64'h0,                   5'd0);
        send_request(rrpst_pkg::KIND_REMOVE,  8'd0,   64'h0,                   5'd0);
        send_request(rrpst_pkg::KIND_ADD,     8'd0,   64'h1111_2222_3333_4444, 5'd3);
        send_request(rrpst_pkg::KIND_ADD,     8'd5,   64'h5555_6666_7777_8888, 5'd0);
        send_request(rrpst_pkg::KIND_ADD,     8'd1,   64'hFFFF_FFFF_FFFF_FFFF, 5'd1);
        send_request(rrpst_pkg::KIND_TICK,    8'd0,   64'h0,                   5'd0);
        send_request(rrpst_pkg::KIND_ADD,     8'd255, 64'h0,                   5'd16);
        send_request(rrpst_pkg::KIND_REPLACE, 8'd255, 64'h0123_4567_89AB_CDEF, 5'd0);
        send_request(rrpst_pkg::KIND_REPLACE, 8'd0,   64'hDEAD_BEEF_CAFE_F00D, 5'd0);
        send_request(rrpst_pkg::KIND_TICK,    8'd0,   64'h0,                   5'd0);
        send_request(rrpst_pkg::KIND_TICK,    8'd0,   64'h0,                   5'd0);
        send_request(rrpst_pkg::KIND_REMOVE,  8'd1,   64'h0,                   5'd0);
        send_request(rrpst_pkg::KIND_REMOVE,  8'd255, 64'h0,                   5'd0);
        send_request(rrpst_pkg::KIND_ADD,     8'hAA,  64'hA5A5_A5A5_5A5A_5A5A, 5'd31);
        send_request(rrpst_pkg::KIND_REMOVE,  8'hAA,  64'h0,                   5'd0);
        send_request(rrpst_pkg::KIND_REPLACE, 8'd0,   64'hFFFF_0000_FFFF_0000, 5'd0);
        send_request(rrpst_pkg::KIND_ADD,     8'd3,   64'h0000_FFFF_0000_FFFF, 5'd1);
        send_request(rrpst_pkg::KIND_REMOVE,  8'd7,   64'h0,                   5'd0);
        send_request(rrpst_pkg::KIND_ADD,     8'd9,   64'h8000_0000_0000_0001, 5'd2);
        send_request(rrpst_pkg::KIND_TICK,    8'd0,   64'h0,                   5'd0);
        send_request(rrpst_pkg::KIND_TICK,    8'd0,   64'h0,                   5'd0);
        send_request(rrpst_pkg::KIND_TICK,    8'd0,   64'h0,                   5'd0);
        send_request(rrpst_pkg::KIND_REMOVE,  8'd3,   64'h0,                   5'd0);
        send_request(rrpst_pkg::KIND_REMOVE,  8'd9,   64'h0,                   5'd0);

        // random phase with sender and receiver idling
        send_random_requests(PHASE_ITEMS);
        wait_drained();

        tx_idle_pct = 53;
        rx_idle_pct = 31;
        send_random_requests(PHASE_ITEMS);
        wait_drained();

        // no idling; receiver holds off while the sender keeps offering
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        hold_request = 1'b1;
        send_request(rrpst_pkg::KIND_ADD, 8'd2, {$urandom, $urandom}, 5'd2);
        for (int n = 0; n < 29; n++) begin
            send_request(rrpst_pkg::KIND_TICK, 8'd0, 64'h0, 5'd0);
        end
        send_random_requests(PHASE_ITEMS);
        s_axis_tvalid <= 1'b0;

        // drain and let the block settle
        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/rrpst_pkg.sv
rtl/core/rrpst_ctrl.sv
rtl/core/rrpst_datapath.sv
rtl/core/round_robin_page_slot_table.sv
dv/page_table_checker.sv
dv/tb_round_robin_page_slot_table.sv
